// ----- hw/rtl/bbs_pkg.sv -----
// types, codes and constants shared by the bollinger band signal block
package bbs_pkg;

    localparam int PRICE_W = 32;
    localparam int TIME_W  = 63;
    localparam int SYM_FW  = 3;
    localparam int WLEN_W  = 7;
    localparam int QTY_W   = 16;
    localparam int AUX_W   = 17;

    // register map: paddr[2] selects the register index
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic [WLEN_W-1:0] WINDOW_RESET = 7'd20;

    // order kinds and sides
    localparam logic KIND_MARKET = 1'b0;
    localparam logic KIND_LIMIT  = 1'b1;
    localparam logic SIDE_SELL   = 1'b0;
    localparam logic SIDE_BUY    = 1'b1;

    typedef struct packed {
        logic [SYM_FW-1:0]  symbol_index;
        logic [PRICE_W-1:0] close_price;
        logic [TIME_W-1:0]  bar_time;
    } in_t;

    typedef struct packed {
        logic [SYM_FW-1:0] out_symbol;
        logic [TIME_W-1:0] out_time;
        logic              order_kind;
        logic              side;
        logic [QTY_W-1:0]  quantity;
        logic [AUX_W-1:0]  aux_price;
        logic              last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_MEAN_DIV,
        ST_LIM_MUL,
        ST_LIM_CMP,
        ST_VAR_SQ,
        ST_VAR_ACC,
        ST_VAR_DIV,
        ST_SQ_LD,
        ST_SQ_STEP,
        ST_SIDE,
        ST_QTY_DIV,
        ST_AUX_LD,
        ST_AUX_DIV,
        ST_EMIT,
        ST_EMIT2
    } state_t;

endpackage

// ----- hw/rtl/bollinger_band_signal.sv -----
// bollinger band signal generator: per-symbol price window, band test and order output
//
//  channel | ports              | direction | carries
//  --------+--------------------+-----------+---------------------------------
//  input   | s_valid/s_ready    | in        | in_t: symbol, close price, time
//  result  | m_valid/m_ready    | out       | out_t: market then optional limit
//  config  | psel/penable/paddr | in        | window_len at address 0
//
//  an item passes through the serial divider (one quotient bit a cycle), the bit-serial
//  square root and the variance walk over the price memory; a limit order adds the
//  quantity and price divides. reset is synchronous; it clears counts, sums and pointers
//  at once, the price memory is never cleared. input is not taken while an item is
//  worked on; a stalled result holds the emit step until the output register frees.
module bollinger_band_signal #(
    parameter int NUM_SYMBOLS = 8,
    parameter int MAX_WINDOW  = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bbs_pkg::in_t         s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bbs_pkg::out_t        m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = 32 + $clog2(MAX_WINDOW);
    localparam int S11_W   = SUM_W + 4;
    localparam int DIV_W   = CNT_W + 4;
    localparam int MEM_D   = NUM_SYMBOLS * MAX_WINDOW;
    localparam int ADDR_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int QDIV_N  = SUM_W - 16;
    localparam int ADIV_N  = S11_W - 16;

    // per-symbol state
    logic [SUM_W-1:0] sum_arr [NUM_SYMBOLS];
    logic [CNT_W-1:0] cnt_arr [NUM_SYMBOLS];
    logic [PTR_W-1:0] ptr_arr [NUM_SYMBOLS];
    logic [31:0]      ring_mem [MEM_D];
    logic [31:0]      mem_rdata_reg;

    logic [bbs_pkg::WLEN_W-1:0] window_len_reg;
    bbs_pkg::state_t state_reg, state_next;

    // item registers
    logic [bbs_pkg::SYM_FW-1:0] sym_reg;
    logic [31:0]      price_reg;
    logic [62:0]      time_reg;
    logic [SUM_W-1:0] sum_old_reg, sum_reg;
    logic [CNT_W-1:0] cnt_old_reg, cnt_cur_reg, k_reg;
    logic [PTR_W-1:0] ptr_old_reg, idx_reg;
    logic [31:0]      mean_reg;
    logic [63:0]      prod_reg, sumsq_reg;
    logic [S11_W-1:0] s11_reg;
    logic             limit_reg, buy_reg;
    logic [15:0]      qty_reg;

    // divider and square root
    logic [63:0]      dvd_reg;
    logic [DIV_W-1:0] rem_reg, den_reg;
    logic [6:0]       dcnt_reg;
    logic [63:0]      sqv_reg, sqr_reg;
    logic [4:0]       sqi_reg;

    logic             m_valid_reg;
    bbs_pkg::out_t    m_data_reg;

    // combinational
    logic [CNT_W-1:0] eff_w, w_m1;
    logic [DIV_W-1:0] w10;
    logic [SYM_W-1:0] in_sidx, sidx;
    logic             sym_ok, accept, cfg_wr, slot_free, load_mkt, load_lim;
    logic [PTR_W-1:0] in_ptr, old_idx, ptr_inc, idx_dec, var_idx;
    logic [CNT_W-1:0] in_cnt;
    logic [SUM_W-1:0] sum_new;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [31:0]      mul_a, mul_b, abs_dev;
    logic [64:0]      sumsq_add;
    logic [63:0]      sumsq_next, sq_bit, sq_trial;
    logic             var_last, sq_ge, div_ge, div_done;
    logic [DIV_W:0]   div_trial;
    logic [37:0]      two16;
    logic [38:0]      upper;
    logic             buy_c;

    // effective window, clamped
    always_comb begin
        if (window_len_reg < 7'd2) begin
            eff_w = CNT_W'(2);
        end else if (32'(window_len_reg) > MAX_WINDOW) begin
            eff_w = CNT_W'(MAX_WINDOW);
        end else begin
            eff_w = CNT_W'(window_len_reg);
        end
        w_m1 = eff_w - CNT_W'(1);
        w10  = DIV_W'(32'(eff_w) * 10);
    end

    // handshakes
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = 32'(window_len_reg);
    assign in_sidx   = SYM_W'(s_data.symbol_index);
    assign sidx      = SYM_W'(sym_reg);
    assign sym_ok    = 32'(s_data.symbol_index) < NUM_SYMBOLS;
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ring addressing
    always_comb begin
        in_ptr  = ptr_arr[in_sidx];
        in_cnt  = cnt_arr[in_sidx];
        if (32'(in_ptr) >= 32'(eff_w)) begin
            old_idx = PTR_W'(32'(in_ptr) - 32'(eff_w));
        end else begin
            old_idx = PTR_W'(32'(in_ptr) + MAX_WINDOW - 32'(eff_w));
        end
        ptr_inc = (32'(ptr_old_reg) == MAX_WINDOW - 1) ? '0 : ptr_old_reg + PTR_W'(1);
        idx_dec = (idx_reg == '0) ? PTR_W'(MAX_WINDOW - 1) : idx_reg - PTR_W'(1);
        var_idx = (state_reg == bbs_pkg::ST_LIM_CMP) ? idx_reg : idx_dec;
        if (state_reg == bbs_pkg::ST_IDLE) begin
            rd_addr = ADDR_W'(32'(in_sidx) * MAX_WINDOW + 32'(old_idx));
        end else begin
            rd_addr = ADDR_W'(32'(sidx) * MAX_WINDOW + 32'(var_idx));
        end
        wr_addr = ADDR_W'(32'(sidx) * MAX_WINDOW + 32'(ptr_old_reg));
    end

    // window sum update
    always_comb begin
        sum_new = sum_old_reg + SUM_W'(price_reg);
        if (cnt_old_reg >= eff_w) begin
            sum_new = sum_new - SUM_W'(mem_rdata_reg);
        end
    end

    // shared multiplier operands
    always_comb begin
        abs_dev = (mem_rdata_reg >= mean_reg) ? mem_rdata_reg - mean_reg
                                              : mean_reg - mem_rdata_reg;
        if (state_reg == bbs_pkg::ST_LIM_MUL) begin
            mul_a = price_reg;
            mul_b = 32'(w10);
        end else begin
            mul_a = abs_dev;
            mul_b = abs_dev;
        end
    end

    // saturating square accumulate
    always_comb begin
        sumsq_add  = 65'(sumsq_reg) + 65'(prod_reg >> 8);
        sumsq_next = sumsq_add[64] ? '1 : sumsq_add[63:0];
        var_last   = (32'(k_reg) + 1) >= 32'(cnt_cur_reg);
    end

    // divider step, one quotient bit a cycle
    always_comb begin
        div_trial = {rem_reg, dvd_reg[63]};
        div_ge    = div_trial >= {1'b0, den_reg};
        div_done  = dcnt_reg == 7'd1;
    end

    // square root step
    always_comb begin
        sq_bit   = 64'(1) << {sqi_reg, 1'b0};
        sq_trial = sqr_reg + sq_bit;
        sq_ge    = sqv_reg >= sq_trial;
    end

    // band test
    always_comb begin
        two16 = {sqr_reg[32:0], 5'd0};
        upper = 39'(mean_reg) + 39'(two16);
        buy_c = (39'(price_reg) < upper) && (38'(mean_reg) >= two16)
             && (38'(price_reg) <= 38'(mean_reg) - two16);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bbs_pkg::ST_IDLE:     if (accept && sym_ok) state_next = bbs_pkg::ST_UPD;
            bbs_pkg::ST_UPD:      state_next = bbs_pkg::ST_MEAN_DIV;
            bbs_pkg::ST_MEAN_DIV: if (div_done) state_next = bbs_pkg::ST_LIM_MUL;
            bbs_pkg::ST_LIM_MUL:  state_next = bbs_pkg::ST_LIM_CMP;
            bbs_pkg::ST_LIM_CMP:  state_next = bbs_pkg::ST_VAR_SQ;
            bbs_pkg::ST_VAR_SQ:   state_next = bbs_pkg::ST_VAR_ACC;
            bbs_pkg::ST_VAR_ACC: begin
                state_next = var_last ? bbs_pkg::ST_VAR_DIV : bbs_pkg::ST_VAR_SQ;
            end
            bbs_pkg::ST_VAR_DIV:  if (div_done) state_next = bbs_pkg::ST_SQ_LD;
            bbs_pkg::ST_SQ_LD:    state_next = bbs_pkg::ST_SQ_STEP;
            bbs_pkg::ST_SQ_STEP:  if (sqi_reg == 5'd0) state_next = bbs_pkg::ST_SIDE;
            bbs_pkg::ST_SIDE: begin
                state_next = limit_reg ? bbs_pkg::ST_QTY_DIV : bbs_pkg::ST_EMIT;
            end
            bbs_pkg::ST_QTY_DIV:  if (div_done) state_next = bbs_pkg::ST_AUX_LD;
            bbs_pkg::ST_AUX_LD:   state_next = bbs_pkg::ST_AUX_DIV;
            bbs_pkg::ST_AUX_DIV:  if (div_done) state_next = bbs_pkg::ST_EMIT;
            bbs_pkg::ST_EMIT: begin
                if (slot_free) begin
                    state_next = limit_reg ? bbs_pkg::ST_EMIT2 : bbs_pkg::ST_IDLE;
                end
            end
            bbs_pkg::ST_EMIT2:    if (slot_free) state_next = bbs_pkg::ST_IDLE;
            default:              state_next = bbs_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready  = 1'b0;
        load_mkt = 1'b0;
        load_lim = 1'b0;
        case (state_reg)
            bbs_pkg::ST_IDLE:  s_ready  = 1'b1;
            bbs_pkg::ST_EMIT:  load_mkt = slot_free;
            bbs_pkg::ST_EMIT2: load_lim = slot_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers and per-symbol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bbs_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            window_len_reg <= bbs_pkg::WINDOW_RESET;
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                sum_arr[i] <= '0;
                cnt_arr[i] <= '0;
                ptr_arr[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_mkt || load_lim) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr && paddr[2] == bbs_pkg::REG_WINDOW_LEN) begin
                window_len_reg <= pwdata[bbs_pkg::WLEN_W-1:0];
                for (int i = 0; i < NUM_SYMBOLS; i++) begin
                    sum_arr[i] <= '0;
                    cnt_arr[i] <= '0;
                    ptr_arr[i] <= '0;
                end
            end else if (state_reg == bbs_pkg::ST_UPD) begin
                sum_arr[sidx] <= sum_new;
                ptr_arr[sidx] <= ptr_inc;
                cnt_arr[sidx] <= (cnt_old_reg < eff_w) ? cnt_old_reg + CNT_W'(1)
                                                       : cnt_old_reg;
            end
        end
    end

    // price memory
    always_ff @(posedge aclk) begin
        mem_rdata_reg <= ring_mem[rd_addr];
        if (state_reg == bbs_pkg::ST_UPD) begin
            ring_mem[wr_addr] <= price_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            bbs_pkg::ST_IDLE: begin
                sym_reg     <= s_data.symbol_index;
                price_reg   <= s_data.close_price;
                time_reg    <= s_data.bar_time;
                sum_old_reg <= sum_arr[in_sidx];
                cnt_old_reg <= in_cnt;
                ptr_old_reg <= in_ptr;
            end
            bbs_pkg::ST_UPD: begin
                sum_reg     <= sum_new;
                cnt_cur_reg <= (cnt_old_reg < eff_w) ? cnt_old_reg + CNT_W'(1) : cnt_old_reg;
                idx_reg     <= ptr_old_reg;
                dvd_reg     <= 64'(sum_new) << (64 - SUM_W);
                rem_reg     <= '0;
                den_reg     <= DIV_W'(eff_w);
                dcnt_reg    <= 7'(SUM_W);
            end
            bbs_pkg::ST_LIM_MUL: begin
                mean_reg <= dvd_reg[31:0];
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            end
            bbs_pkg::ST_LIM_CMP: begin
                limit_reg <= prod_reg > 64'((S11_W'(sum_reg) << 3) + (S11_W'(sum_reg) << 1)
                                            + S11_W'(sum_reg));
                s11_reg   <= (S11_W'(sum_reg) << 3) + (S11_W'(sum_reg) << 1) + S11_W'(sum_reg);
                sumsq_reg <= '0;
                k_reg     <= '0;
            end
            bbs_pkg::ST_VAR_SQ: begin
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            end
            bbs_pkg::ST_VAR_ACC: begin
                sumsq_reg <= sumsq_next;
                k_reg     <= k_reg + CNT_W'(1);
                idx_reg   <= idx_dec;
                if (var_last) begin
                    dvd_reg  <= sumsq_next;
                    rem_reg  <= '0;
                    den_reg  <= DIV_W'(w_m1);
                    dcnt_reg <= 7'd64;
                end
            end
            bbs_pkg::ST_MEAN_DIV, bbs_pkg::ST_VAR_DIV, bbs_pkg::ST_QTY_DIV,
            bbs_pkg::ST_AUX_DIV: begin
                dvd_reg  <= {dvd_reg[62:0], div_ge};
                rem_reg  <= div_ge ? DIV_W'(div_trial - {1'b0, den_reg}) : DIV_W'(div_trial);
                dcnt_reg <= dcnt_reg - 7'd1;
            end
            bbs_pkg::ST_SQ_LD: begin
                sqv_reg <= dvd_reg;
                sqr_reg <= '0;
                sqi_reg <= 5'd31;
            end
            bbs_pkg::ST_SQ_STEP: begin
                if (sq_ge) begin
                    sqv_reg <= sqv_reg - sq_trial;
                    sqr_reg <= (sqr_reg >> 1) + sq_bit;
                end else begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqi_reg <= sqi_reg - 5'd1;
            end
            bbs_pkg::ST_SIDE: begin
                buy_reg  <= buy_c;
                dvd_reg  <= 64'(sum_reg >> 16) << (64 - QDIV_N);
                rem_reg  <= '0;
                den_reg  <= w10;
                dcnt_reg <= 7'(QDIV_N);
            end
            bbs_pkg::ST_AUX_LD: begin
                qty_reg  <= dvd_reg[15:0];
                dvd_reg  <= 64'(s11_reg >> 16) << (64 - ADIV_N);
                rem_reg  <= '0;
                dcnt_reg <= 7'(ADIV_N);
            end
            default: begin
                sym_reg <= sym_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (load_mkt) begin
            m_data_reg.out_symbol <= sym_reg;
            m_data_reg.out_time   <= time_reg;
            m_data_reg.order_kind <= bbs_pkg::KIND_MARKET;
            m_data_reg.side       <= buy_reg ? bbs_pkg::SIDE_BUY : bbs_pkg::SIDE_SELL;
            m_data_reg.quantity   <= 16'd1;
            m_data_reg.aux_price  <= '0;
            m_data_reg.last       <= !limit_reg;
        end else if (load_lim) begin
            m_data_reg.out_symbol <= sym_reg;
            m_data_reg.out_time   <= time_reg;
            m_data_reg.order_kind <= bbs_pkg::KIND_LIMIT;
            m_data_reg.side       <= bbs_pkg::SIDE_BUY;
            m_data_reg.quantity   <= qty_reg;
            m_data_reg.aux_price  <= dvd_reg[16:0];
            m_data_reg.last       <= 1'b1;
        end
    end

    // checks
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && sym_ok |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbs_pkg::ST_MEAN_DIV || state_reg == bbs_pkg::ST_VAR_DIV ||
         state_reg == bbs_pkg::ST_QTY_DIV || state_reg == bbs_pkg::ST_AUX_DIV)
        |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_count_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbs_pkg::ST_VAR_SQ |-> cnt_cur_reg <= eff_w && cnt_cur_reg != '0)
        else $error("sample count outside window");

    a_limit_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.order_kind == bbs_pkg::KIND_LIMIT |-> m_data.last)
        else $error("limit order not flagged last");

endmodule

// ----- tb/sv/tb.sv -----
// testbench for bollinger_band_signal: directed and random bars checked against a band predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM       = 8;
    localparam int MAXW       = 64;
    localparam int DRAIN_WAIT = 600;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] ADDR_WINDOW_LEN = {bbs_pkg::REG_WINDOW_LEN, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    bbs_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    bbs_pkg::out_t m_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    bollinger_band_signal dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 aclk = ~aclk;

    // predictor state: one price window per symbol
    logic [31:0]      price_hist [NSYM][MAXW];
    logic [63:0]      win_sum    [NSYM];
    int unsigned      held       [NSYM];
    int unsigned      wr_slot    [NSYM];
    logic [6:0]       window_reg;
    logic [31:0]      base_price [NSYM];

    bbs_pkg::out_t expected_orders [$];
    int   error_count   = 0;
    int   bars_sent     = 0;
    int   orders_seen   = 0;
    int   limit_orders  = 0;
    int   buy_signals   = 0;
    bit   steady_sender = 1'b0;
    bit   steady_reader = 1'b0;
    int   idle_cycles   = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root   = 64'd0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v    = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic int unsigned eff_window();
        if (window_reg < 2) return 2;
        if (window_reg > MAXW) return MAXW;
        return 32'(window_reg);
    endfunction

    task automatic clear_history();
        for (int s = 0; s < NSYM; s++) begin
            win_sum[s] = 64'd0;
            held[s]    = 0;
            wr_slot[s] = 0;
        end
    endtask

    // append one order at the tail of the expected queue
    task automatic queue_order(bbs_pkg::out_t o);
        expected_orders = {expected_orders, o};
    endtask

    // update the window for one bar and queue the orders it should produce
    task automatic predict_band_signal(bbs_pkg::in_t bar);
        int unsigned w, sym, p, idx;
        logic [63:0] s, mean, sumsq, var_q, two16, upper, d, sq, den;
        logic [63:0] price;
        bit buy, is_limit;
        bbs_pkg::out_t o;
        w     = eff_window();
        sym   = 32'(bar.symbol_index);
        price = {32'd0, bar.close_price};
        p     = wr_slot[sym];
        s     = win_sum[sym];
        if (held[sym] >= w) s = s - price_hist[sym][(p + MAXW - w) % MAXW];
        s = s + price;
        price_hist[sym][p] = bar.close_price;
        p = (p + 1) % MAXW;
        if (held[sym] < w) held[sym]++;
        wr_slot[sym] = p;
        win_sum[sym] = s;

        mean  = s / w;
        sumsq = 64'd0;
        for (int k = 0; k < held[sym]; k++) begin
            idx = (p + 2 * MAXW - 1 - k) % MAXW;
            d   = (price_hist[sym][idx] >= mean) ? price_hist[sym][idx] - mean
                                                  : mean - price_hist[sym][idx];
            sq  = (d * d) >> 8;
            if (sumsq > ~sq) sumsq = '1;
            else sumsq = sumsq + sq;
        end
        var_q = sumsq / (w - 1);
        two16 = int_sqrt(var_q) << 5;
        upper = mean + two16;
        if (price >= upper) buy = 1'b0;
        else buy = (two16 <= mean) && (price <= mean - two16);
        is_limit = (64'd10 * w * price) > (64'd11 * s);

        o.out_symbol = bar.symbol_index;
        o.out_time   = bar.bar_time;
        o.order_kind = bbs_pkg::KIND_MARKET;
        o.side       = buy ? bbs_pkg::SIDE_BUY : bbs_pkg::SIDE_SELL;
        o.quantity   = 16'd1;
        o.aux_price  = '0;
        o.last       = !is_limit;
        queue_order(o);
        if (buy) buy_signals++;
        if (is_limit) begin
            den         = 64'd10 * w * 64'd65536;
            o.order_kind = bbs_pkg::KIND_LIMIT;
            o.side       = bbs_pkg::SIDE_BUY;
            o.quantity   = 16'((s / den) & 64'hFFFF);
            o.aux_price  = 17'(((64'd11 * s) / den) & 64'h1FFFF);
            o.last       = 1'b1;
            queue_order(o);
            limit_orders++;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (steady_sender) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // one bar transfer on the input channel
    task automatic send_bar(logic [2:0] sym, logic [31:0] price, logic [62:0] t);
        bbs_pkg::in_t bar;
        int  gap;
        bar.symbol_index = sym;
        bar.close_price  = price;
        bar.bar_time     = t;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= bar;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_band_signal(bar);
        bars_sent++;
    endtask

    function automatic logic [62:0] rand_time();
        return 63'({$urandom, $urandom});
    endfunction

    // price around the symbol's level, with spikes up and drops down
    function automatic logic [31:0] market_price(int sym);
        int r;
        logic [31:0] span;
        r    = $urandom_range(0, 99);
        span = base_price[sym] >> $urandom_range(3, 9);
        if (r < 3) return $urandom;
        if (r < 12) return base_price[sym] + (base_price[sym] >> 2) + (span >> 1);
        if (r < 21) return base_price[sym] - (base_price[sym] >> 2) - (span >> 1);
        if (r < 60) base_price[sym] = base_price[sym] + $urandom_range(0, 255) - 128;
        return base_price[sym] - (span >> 1) + ($urandom % (span + 1));
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_orders.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WINDOW_LEN) begin
            window_reg = value[6:0];
            clear_history();
        end
    endtask

    task automatic set_window(logic [31:0] value);
        wait_drained();
        apb_write(ADDR_WINDOW_LEN, value);
    endtask

    task automatic random_bars(int n);
        int sym;
        for (int i = 0; i < n; i++) begin
            sym = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NSYM - 1)
                                              : $urandom_range(0, 2);
            send_bar(3'(sym), market_price(sym), rand_time());
        end
    endtask

    // field extremes, every symbol, wrap of the window, limit and buy cases
    task automatic test_directed();
        set_window(32'd4);
        send_bar(3'd0, 32'h0000_0000, 63'd0);
        send_bar(3'd0, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
        send_bar(3'd0, 32'hFFFF_FFFF, 63'h5555_5555_5555_5555);
        send_bar(3'd0, 32'hFFFF_FFFF, 63'h2AAA_AAAA_AAAA_AAAA);
        send_bar(3'd0, 32'hFFFF_FFFF, 63'd1);
        send_bar(3'd0, 32'h0000_0000, 63'd2);
        for (int s = 0; s < NSYM; s++) send_bar(3'(s), 32'h0064_0000, 63'(s));
        for (int i = 0; i < 5; i++) send_bar(3'd1, 32'h0064_0000, 63'(100 + i));
        send_bar(3'd1, 32'h0080_0000, 63'd200);
        send_bar(3'd1, 32'h0064_0000, 63'd201);
        send_bar(3'd1, 32'h0010_0000, 63'd202);
        send_bar(3'd7, 32'h0001_0000, 63'd203);
        send_bar(3'd7, 32'h0000_0001, 63'd204);
    endtask

    // window extremes, clamping and a write to an unmapped register
    task automatic test_window_settings();
        logic [31:0] settings [7];
        settings = '{32'd0, 32'd1, 32'd2, 32'd64, 32'd127, 32'hFFFF_FF85, 32'd20};
        foreach (settings[i]) begin
            set_window(settings[i]);
            random_bars(80);
        end
        wait_drained();
        apb_write(ADDR_UNMAPPED, 32'd3);
        random_bars(60);
    endtask

    // back-to-back bars with the result side always ready
    task automatic test_no_idle();
        set_window(32'd8);
        steady_sender = 1'b1;
        steady_reader = 1'b1;
        random_bars(120);
        steady_sender = 1'b0;
        steady_reader = 1'b0;
    endtask

    // sender holds back until all outstanding orders are out
    task automatic test_drain_pause();
        for (int b = 0; b < 6; b++) begin
            random_bars($urandom_range(5, 20));
            s_valid <= 1'b0;
            while (expected_orders.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            set_window($urandom_range(2, 64));
            random_bars(120);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (order %0d)", what, got, want,
                 orders_seen);
        error_count++;
    endtask

    // result side back-pressure
    int stall_left = 0;
    always @(posedge aclk) begin
        if (steady_reader) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 99) < 30) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 2);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expected order
    always @(posedge aclk) begin
        bbs_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            orders_seen++;
            if (expected_orders.size() == 0) begin
                report_mismatch("unexpected order", {1'b0, m_data.out_time}, 64'd0);
            end else begin
                want = expected_orders.pop_front();
                if (m_data.out_symbol != want.out_symbol)
                    report_mismatch("out_symbol", 64'(m_data.out_symbol),
                                    64'(want.out_symbol));
                if (m_data.out_time != want.out_time)
                    report_mismatch("out_time", 64'(m_data.out_time), 64'(want.out_time));
                if (m_data.order_kind != want.order_kind)
                    report_mismatch("order_kind", 64'(m_data.order_kind),
                                    64'(want.order_kind));
                if (m_data.side != want.side)
                    report_mismatch("side", 64'(m_data.side), 64'(want.side));
                if (m_data.quantity != want.quantity)
                    report_mismatch("quantity", 64'(m_data.quantity), 64'(want.quantity));
                if (m_data.aux_price != want.aux_price)
                    report_mismatch("aux_price", 64'(m_data.aux_price),
                                    64'(want.aux_price));
                if (m_data.last != want.last)
                    report_mismatch("last", 64'(m_data.last), 64'(want.last));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        window_reg = bbs_pkg::WINDOW_RESET;
        clear_history();
        for (int s = 0; s < NSYM; s++) base_price[s] = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        random_bars(30);
        test_directed();
        test_window_settings();
        test_no_idle();
        test_drain_pause();
        test_random();

        wait_drained();
        if (expected_orders.size() != 0) begin
            report_mismatch("orders never arrived", 64'(expected_orders.size()), 64'd0);
        end
        $display("sent %0d bars over several window lengths, checked %0d orders", bars_sent,
                 orders_seen);
        $display("of which %0d limit orders and %0d buy signals", limit_orders, buy_signals);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
